// ===== design/ebrc_pkg.sv =====
package ebrc_pkg;

    localparam int unsigned DataDepthDefault = 256;

    localparam logic [1:0] FaultNone    = 2'd0;
    localparam logic [1:0] FaultInvalid = 2'd1;
    localparam logic [1:0] FaultDivZero = 2'd2;

    localparam logic [7:0] OpNop     = 8'hf8;
    localparam logic [7:0] OpPushImm = 8'hf9;
    localparam logic [7:0] OpJmp     = 8'hfa;
    localparam logic [7:0] OpJe      = 8'hfb;
    localparam logic [7:0] OpJg      = 8'hfc;
    localparam logic [7:0] OpJl      = 8'hfd;

    localparam logic [1:0] FlagEq = 2'b01;
    localparam logic [1:0] FlagGt = 2'b10;

    // ALU operation codes
    localparam logic [2:0] AluAdd = 3'd0;
    localparam logic [2:0] AluSub = 3'd1;
    localparam logic [2:0] AluMul = 3'd2;
    localparam logic [2:0] AluDiv = 3'd3;
    localparam logic [2:0] AluMod = 3'd4;
    localparam logic [2:0] AluAnd = 3'd5;
    localparam logic [2:0] AluOr  = 3'd6;

    localparam logic [1:0] RegSp = 2'd3;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MEMRD,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [7:0] next_pc;
        logic       used_operand;
        logic [1:0] fault;
        logic [7:0] reg_a;
        logic [7:0] reg_b;
        logic [7:0] reg_c;
        logic [7:0] stack_ptr;
        logic [1:0] cond_flags;
    } t_result;

    typedef struct packed {
        logic [7:0] opcode;
        logic [7:0] operand_byte;
    } t_instr;

endpackage

// ===== design/ebrc_if.sv =====
interface ebrc_in_if import ebrc_pkg::*; ();
    logic   valid;
    logic   ready;
    t_instr data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ebrc_out_if import ebrc_pkg::*; ();
    logic    valid;
    logic    ready;
    t_result data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/ebrc_ram.sv =====
module ebrc_ram #(
    parameter int unsigned Width = 8,
    parameter int unsigned Depth = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== design/ebrc_div.sv =====
// Restoring divider, one quotient bit per cycle
module ebrc_div import ebrc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [7:0] i_dividend,
    input  logic [7:0] i_divisor,
    output logic       o_done,
    output logic [7:0] o_quot,
    output logic [7:0] o_rem
);
    logic [7:0] r_quot, r_rem, r_dvs;
    logic [3:0] r_cnt;
    logic       r_busy;
    logic [8:0] trial;

    assign trial = {r_rem[7:0], r_quot[7]} - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 4'd8;
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 4'd1;
            if (r_cnt == 4'd1) begin
                r_busy <= 1'b0;
            end
            if (!trial[8]) begin
                r_rem <= trial[7:0];
                r_quot <= {r_quot[6:0], 1'b1};
            end else begin
                r_rem <= {r_rem[6:0], r_quot[7]};
                r_quot <= {r_quot[6:0], 1'b0};
            end
        end
    end

    assign o_done = r_busy && (r_cnt == 4'd1);
    // final-step values
    assign o_quot = {r_quot[6:0], ~trial[8]};
    assign o_rem  = trial[8] ? {r_rem[6:0], r_quot[7]} : trial[7:0];
endmodule

// ===== design/eight_bit_register_cpu_execute.sv =====
// Path from acceptance to result valid: ops without a memory read or divide
// finish in MEMRD, pop and load go MEMRD then DONE, and div/mod by a nonzero
// register or immediate go MEMRD then DIV. Throughput: one instruction at a time;
// the next one is taken only in IDLE once the previous result has been taken.
// Reset: synchronous active low; registers, flags and PC clear, then a clearing
// pass zeroes the data memory.
module eight_bit_register_cpu_execute import ebrc_pkg::*; #(
    parameter int unsigned DATA_DEPTH = DataDepthDefault
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ebrc_in_if.sink         i_instr,
    ebrc_out_if.source      o_result
);
    localparam int unsigned AW = $clog2(DATA_DEPTH);

    t_state     r_state, n_state;
    logic [7:0] r_regs [4];
    logic [1:0] r_flags;
    logic [7:0] r_pc;
    logic [7:0] r_op, r_imm;
    logic [AW-1:0] r_clr;
    logic       r_ovalid;
    t_result    r_out;

    logic [1:0] d, s;
    logic [3:0] hi;
    logic [7:0] rd, rs;
    logic [2:0] aop;
    logic       is_alu_reg, is_alu_imm, is_alu, is_div;
    logic [7:0] alu_l, alu_r, alu_res;
    logic [15:0] prod;

    // memory access signals
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    mem_wdata, mem_rdata;

    logic       div_start, div_done;
    logic [7:0] div_q, div_r;

    // finish-step outputs
    logic       fin;
    logic [7:0] wr_val;
    logic [1:0] wr_reg;
    logic       wr_en, sp_inc, sp_dec, flg_en;
    logic [1:0] flg_val;
    logic       used, jump;
    logic [1:0] fault;

    assign hi  = r_op[7:4];
    assign d   = r_op[3:2];
    assign s   = r_op[1:0];
    assign rd  = r_regs[d];
    assign rs  = r_regs[s];
    assign is_alu_reg = (hi >= 4'h2) && (hi <= 4'h9);
    assign is_alu_imm = (hi == 4'hb) || (hi == 4'hc);
    assign is_alu = is_alu_reg || is_alu_imm;
    assign aop = is_alu_reg ? 3'(hi - 4'h2) : 3'(8'(r_op - 8'hb0) >> 2);
    assign alu_l = is_alu_reg ? rd : rs;
    assign alu_r = is_alu_reg ? rs : r_imm;
    assign is_div = is_alu && ((aop == AluDiv) || (aop == AluMod)) && (alu_r != 8'd0);
    assign prod = 16'(alu_l) * 16'(alu_r);

    // ALU result
    always_comb begin
        unique case (aop)
            AluAdd:  alu_res = alu_l + alu_r;
            AluSub:  alu_res = alu_l - alu_r;
            AluMul:  alu_res = prod[7:0];
            AluDiv:  alu_res = (alu_r == 8'd0) ? 8'hff : div_q;
            AluMod:  alu_res = (alu_r == 8'd0) ? alu_l : div_r;
            AluAnd:  alu_res = alu_l & alu_r;
            AluOr:   alu_res = alu_l | alu_r;
            default: alu_res = alu_l ^ alu_r;
        endcase
    end

    function automatic logic [1:0] cmp(input logic [7:0] l, input logic [7:0] r);
        return {l > r, l == r};
    endfunction

    // memory read needed: pop or load
    logic needs_rd;
    assign needs_rd = (hi == 4'he) && (d[1] == 1'b1);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (r_clr == AW'(DATA_DEPTH - 1)) n_state = ST_IDLE;
            ST_IDLE:  if (i_instr.valid && !r_ovalid) n_state = ST_MEMRD;
            ST_MEMRD: begin
                if (is_div) n_state = ST_DIV;
                else if (needs_rd) n_state = ST_DONE;
                else n_state = ST_IDLE;
            end
            ST_DIV:   if (div_done) n_state = ST_IDLE;
            ST_DONE:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    assign i_instr.ready = (r_state == ST_IDLE) && !r_ovalid;
    assign div_start = (r_state == ST_MEMRD) && is_div;
    assign fin = ((r_state == ST_MEMRD) && !is_div && !needs_rd)
              || (r_state == ST_DONE) || div_done;

    // memory port control; read issued in MEMRD, data in DONE
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_clr;
        mem_wdata = 8'd0;
        mem_raddr = AW'(r_imm);
        if (hi == 4'he && d == 2'd2) mem_raddr = AW'(r_regs[RegSp] - 8'd1);
        if (r_state == ST_CLEAR) begin
            mem_we = 1'b1;
        end else if (r_state == ST_MEMRD) begin
            if (hi == 4'h1) begin
                mem_we = 1'b1; mem_waddr = AW'(rd); mem_wdata = rs;
            end else if (hi == 4'he && d == 2'd0) begin
                mem_we = 1'b1; mem_waddr = AW'(rs); mem_wdata = r_imm;
            end else if (hi == 4'he && d == 2'd1) begin
                mem_we = 1'b1; mem_waddr = AW'(r_regs[RegSp]); mem_wdata = rs;
            end else if (r_op == OpPushImm) begin
                mem_we = 1'b1; mem_waddr = AW'(r_regs[RegSp]); mem_wdata = r_imm;
            end
        end
    end

    ebrc_ram #(.Width(8), .Depth(DATA_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    ebrc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (alu_l),
        .i_divisor  (alu_r),
        .o_done     (div_done),
        .o_quot     (div_q),
        .o_rem      (div_r)
    );

    // decode of state updates at finish
    always_comb begin
        wr_en = 1'b0; wr_reg = s; wr_val = alu_res;
        sp_inc = 1'b0; sp_dec = 1'b0;
        flg_en = 1'b0; flg_val = cmp(rd, rs);
        used = 1'b0; jump = 1'b0; fault = FaultNone;
        if (hi == 4'h0) begin
            wr_en = 1'b1; wr_reg = d; wr_val = rs;
        end else if (hi == 4'h1) begin
            wr_en = 1'b0;
        end else if (is_alu_reg) begin
            wr_en = 1'b1; wr_reg = d;
            if ((aop == AluDiv || aop == AluMod) && alu_r == 8'd0) fault = FaultDivZero;
        end else if (hi == 4'ha) begin
            flg_en = 1'b1;
        end else if (is_alu_imm) begin
            wr_en = 1'b1; used = 1'b1;
            if ((aop == AluDiv || aop == AluMod) && alu_r == 8'd0) fault = FaultDivZero;
        end else if (hi == 4'hd) begin
            wr_en = 1'b1;
            unique case (d)
                2'd0: wr_val = ~rs;
                2'd1: wr_val = rs + 8'd1;
                2'd2: wr_val = rs - 8'd1;
                default: begin wr_val = r_imm; used = 1'b1; end
            endcase
        end else if (hi == 4'he) begin
            unique case (d)
                2'd0: used = 1'b1;
                2'd1: sp_inc = 1'b1;
                2'd2: begin sp_dec = 1'b1; wr_en = 1'b1; wr_val = mem_rdata; end
                default: begin used = 1'b1; wr_en = 1'b1; wr_val = mem_rdata; end
            endcase
        end else begin
            priority if (r_op[7:2] == 6'b111100) begin
                used = 1'b1; flg_en = 1'b1; flg_val = cmp(rs, r_imm);
            end else if (r_op == OpNop) begin
                used = 1'b0;
            end else if (r_op == OpPushImm) begin
                used = 1'b1; sp_inc = 1'b1;
            end else if (r_op == OpJmp) begin
                used = 1'b1; jump = 1'b1;
            end else if (r_op == OpJe) begin
                used = 1'b1; jump = (r_flags & FlagEq) != 2'b00;
            end else if (r_op == OpJg) begin
                used = 1'b1; jump = (r_flags & FlagGt) != 2'b00;
            end else if (r_op == OpJl) begin
                used = 1'b1; jump = r_flags == 2'b00;
            end else begin
                fault = FaultInvalid;
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_flags  <= '0;
            r_pc     <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < 4; i++) r_regs[i] <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr <= r_clr + AW'(1);
            if (i_instr.valid && i_instr.ready) begin
                r_op  <= i_instr.data.opcode;
                r_imm <= i_instr.data.operand_byte;
            end
            if (o_result.ready && !fin) r_ovalid <= 1'b0;
            if (fin) begin
                automatic logic [7:0] sp_n = r_regs[RegSp];
                automatic logic [7:0] pc_n = r_pc;
                automatic logic [7:0] regs_n [4];
                automatic logic [1:0] flg_n = r_flags;
                for (int i = 0; i < 4; i++) regs_n[i] = r_regs[i];
                if (sp_inc) sp_n = sp_n + 8'd1;
                if (sp_dec) sp_n = sp_n - 8'd1;
                regs_n[RegSp] = sp_n;
                if (wr_en) regs_n[wr_reg] = wr_val;
                if (flg_en) flg_n = flg_val;
                if (fault != FaultInvalid) begin
                    pc_n = jump ? r_imm : r_pc + 8'd1 + {7'd0, used};
                end
                for (int i = 0; i < 4; i++) r_regs[i] <= regs_n[i];
                r_flags  <= flg_n;
                r_pc     <= pc_n;
                r_ovalid <= 1'b1;
                r_out    <= '{next_pc: pc_n, used_operand: used, fault: fault,
                              reg_a: regs_n[0], reg_b: regs_n[1], reg_c: regs_n[2],
                              stack_ptr: regs_n[3], cond_flags: flg_n};
            end
        end
    end

    assign o_result.valid = r_ovalid;
    assign o_result.data  = r_out;
endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import ebrc_pkg::*;

    localparam int unsigned NumRandom  = 1250;
    localparam int unsigned StallLimit = 20000;
    localparam int unsigned DrainWait  = 40;

    // Opcode group codes (bits 7:4)
    localparam logic [3:0] GrpMov   = 4'h0;
    localparam logic [3:0] GrpStore = 4'h1;
    localparam logic [3:0] GrpCmp   = 4'ha;
    localparam logic [3:0] GrpAluI0 = 4'hb;
    localparam logic [3:0] GrpAluI1 = 4'hc;
    localparam logic [3:0] GrpUnary = 4'hd;
    localparam logic [3:0] GrpStack = 4'he;

    // Sub-ops within unary and stack groups
    localparam logic [1:0] UnNot = 2'd0;
    localparam logic [1:0] UnInc = 2'd1;
    localparam logic [1:0] UnDec = 2'd2;
    localparam logic [1:0] StkStoreImm = 2'd0;
    localparam logic [1:0] StkPush     = 2'd1;
    localparam logic [1:0] StkPop      = 2'd2;

    localparam logic [7:0] OpCmpImm0 = 8'hf0;
    localparam logic [7:0] OpCmpImm3 = 8'hf3;

    logic i_clk;
    logic i_rst_n;

    ebrc_in_if  instr_if ();
    ebrc_out_if result_if ();

    eight_bit_register_cpu_execute i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_instr (instr_if.sink),
        .o_result(result_if.source)
    );

    // Scoreboard: architectural model plus queue of pending results
    class cpu_scoreboard;
        logic [7:0] regs [4];
        logic [1:0] flags;
        logic [7:0] pc;
        logic [7:0] mem [256];
        t_result    pending [$];
        int         errors;

        function void clear();
            foreach (regs[i]) regs[i] = '0;
            foreach (mem[i]) mem[i] = '0;
            flags   = '0;
            pc      = '0;
            errors  = 0;
            pending.delete();
        endfunction

        function logic [1:0] cmp_flags(logic [7:0] l, logic [7:0] r);
            logic [1:0] f;
            f = '0;
            if (l == r) f |= FlagEq;
            if (l > r) f |= FlagGt;
            return f;
        endfunction

        function logic [7:0] alu(logic [2:0] op, logic [7:0] l, logic [7:0] r,
                                 inout logic [1:0] flt);
            case (op)
                AluAdd: return l + r;
                AluSub: return l - r;
                AluMul: return l * r;
                AluDiv: begin
                    if (r == 8'd0) begin
                        flt = FaultDivZero;
                        return 8'hff;
                    end
                    return l / r;
                end
                AluMod: begin
                    if (r == 8'd0) begin
                        flt = FaultDivZero;
                        return l;
                    end
                    return l % r;
                end
                AluAnd: return l & r;
                AluOr:  return l | r;
                default: return l ^ r;
            endcase
        endfunction

        // Execute one accepted instruction and queue its result
        function void note_instr(t_instr it);
            logic [7:0] op, imm, sp, v, tgt;
            logic [3:0] hi;
            logic [1:0] d, s, flt;
            logic       used, jmp;
            t_result    r;
            op = it.opcode;
            imm = it.operand_byte;
            hi = op[7:4];
            d = op[3:2];
            s = op[1:0];
            flt = FaultNone;
            used = 1'b0;
            jmp = 1'b0;
            tgt = imm;
            if (hi <= 4'h9) begin
                if (hi == GrpMov) regs[d] = regs[s];
                else if (hi == GrpStore) mem[regs[d]] = regs[s];
                else regs[d] = alu(3'(hi - 4'h2), regs[d], regs[s], flt);
            end else if (hi == GrpCmp) begin
                flags = cmp_flags(regs[d], regs[s]);
            end else if (hi == GrpAluI0 || hi == GrpAluI1) begin
                used = 1'b1;
                regs[s] = alu(3'((op - 8'hb0) >> 2), regs[s], imm, flt);
            end else if (hi == GrpUnary) begin
                v = regs[s];
                case (d)
                    UnNot: v = ~v;
                    UnInc: v = v + 8'd1;
                    UnDec: v = v - 8'd1;
                    default: begin
                        v = imm;
                        used = 1'b1;
                    end
                endcase
                regs[s] = v;
            end else if (hi == GrpStack) begin
                sp = regs[RegSp];
                case (d)
                    StkStoreImm: begin
                        used = 1'b1;
                        mem[regs[s]] = imm;
                    end
                    StkPush: begin
                        mem[sp] = regs[s];
                        regs[RegSp] = sp + 8'd1;
                    end
                    StkPop: begin
                        sp = sp - 8'd1;
                        regs[RegSp] = sp;
                        regs[s] = mem[sp];
                    end
                    default: begin
                        used = 1'b1;
                        regs[s] = mem[imm];
                    end
                endcase
            end else begin
                if (op >= OpCmpImm0 && op <= OpCmpImm3) begin
                    used = 1'b1;
                    flags = cmp_flags(regs[s], imm);
                end else if (op == OpNop) begin
                end else if (op == OpPushImm) begin
                    used = 1'b1;
                    mem[regs[RegSp]] = imm;
                    regs[RegSp] = regs[RegSp] + 8'd1;
                end else if (op == OpJmp) begin
                    used = 1'b1;
                    jmp = 1'b1;
                end else if (op == OpJe) begin
                    used = 1'b1;
                    jmp = (flags & FlagEq) != 2'b00;
                end else if (op == OpJg) begin
                    used = 1'b1;
                    jmp = (flags & FlagGt) != 2'b00;
                end else if (op == OpJl) begin
                    used = 1'b1;
                    jmp = (flags & (FlagEq | FlagGt)) == 2'b00;
                end else begin
                    flt = FaultInvalid;
                end
            end
            if (flt != FaultInvalid) pc = jmp ? tgt : pc + 8'd1 + 8'(used);
            r.next_pc      = pc;
            r.used_operand = used;
            r.fault        = flt;
            r.reg_a        = regs[0];
            r.reg_b        = regs[1];
            r.reg_c        = regs[2];
            r.stack_ptr    = regs[3];
            r.cond_flags   = flags;
            pending.push_back(r);
        endfunction

        function void report(string fld, logic [7:0] e, logic [7:0] a);
            $display("%0t: mismatch %s expected %0h actual %0h", $time, fld, e, a);
            errors++;
        endfunction

        // Compare one received result with the oldest pending one
        function void check_result(t_result a);
            t_result e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %0h", $time, a);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.next_pc !== e.next_pc) report("next_pc", e.next_pc, a.next_pc);
            if (a.used_operand !== e.used_operand)
                report("used_operand", 8'(e.used_operand), 8'(a.used_operand));
            if (a.fault !== e.fault) report("fault", 8'(e.fault), 8'(a.fault));
            if (a.reg_a !== e.reg_a) report("reg_a", e.reg_a, a.reg_a);
            if (a.reg_b !== e.reg_b) report("reg_b", e.reg_b, a.reg_b);
            if (a.reg_c !== e.reg_c) report("reg_c", e.reg_c, a.reg_c);
            if (a.stack_ptr !== e.stack_ptr) report("stack_ptr", e.stack_ptr, a.stack_ptr);
            if (a.cond_flags !== e.cond_flags)
                report("cond_flags", 8'(e.cond_flags), 8'(a.cond_flags));
        endfunction
    endclass

    cpu_scoreboard sb;
    int unsigned   idle_cycles;
    logic          hold_sink;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Mostly short gaps, occasionally long ones
    function automatic int unsigned gap_len();
        int unsigned p;
        p = $urandom_range(99);
        if (p < 45) return 0;
        if (p < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    task automatic send_instr(logic [7:0] op, logic [7:0] imm);
        instr_if.valid <= 1'b1;
        instr_if.data  <= '{opcode: op, operand_byte: imm};
        @(posedge i_clk);
        while (!instr_if.ready) @(posedge i_clk);
        sb.note_instr('{opcode: op, operand_byte: imm});
    endtask

    task automatic pause_sender(int unsigned n);
        instr_if.valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic send_gap(logic [7:0] op, logic [7:0] imm);
        int unsigned g;
        send_instr(op, imm);
        g = gap_len();
        if (g != 0) pause_sender(g);
    endtask

    // Random operand values biased toward the edges
    function automatic logic [7:0] rand_byte();
        case ($urandom_range(5))
            0: return 8'h00;
            1: return 8'hff;
            2: return 8'($urandom_range(3));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Receiver: random stalls, plus one long hold-off
    initial begin
        int unsigned g;
        result_if.ready <= 1'b0;
        @(posedge i_clk);
        while (1) begin
            if (hold_sink) begin
                result_if.ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_sink = 1'b0;
            end
            g = gap_len();
            if (g != 0) begin
                result_if.ready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
            result_if.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // Monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n && result_if.valid && result_if.ready) sb.check_result(result_if.data);
        if ((instr_if.valid && instr_if.ready) || (result_if.valid && result_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > StallLimit) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Stimulus
    initial begin
        int unsigned n;
        logic [7:0]  op;
        sb = new();
        sb.clear();
        idle_cycles = 0;
        hold_sink = 1'b0;
        instr_if.valid <= 1'b0;
        instr_if.data  <= '0;
        i_rst_n <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: edges, div/mod by zero, stack, jumps, invalid opcodes
        send_gap(8'hdf, 8'hff);       // mov sp, 0xff
        send_gap(8'he4, 8'h00);       // push a at 0xff, sp wraps to 0
        send_gap(8'he8, 8'h00);       // pop a, sp back to 0xff
        send_gap(8'he7, 8'h00);       // push sp
        send_gap(8'heb, 8'h00);       // pop into sp
        send_gap(8'hdc, 8'h00);       // mov a, 0
        send_gap(8'hdd, 8'hff);       // mov b, 0xff
        send_gap(8'h31, 8'h00);       // sub a, b
        send_gap(8'h34, 8'h00);       // sub b, a
        send_gap(8'h44, 8'h00);       // mul b, a
        send_gap(8'hbc, 8'h00);       // div imm zero
        send_gap(8'hc1, 8'h00);       // mod imm zero
        send_gap(8'hb9, 8'h07);       // mul imm
        send_gap(8'ha1, 8'h00);       // cmp a, b
        send_gap(8'hfd, 8'h40);       // jl
        send_gap(8'hf1, 8'hff);       // cmp b, imm (less)
        send_gap(8'hfb, 8'hfe);       // je not taken
        send_gap(8'hfc, 8'h10);       // jg not taken
        send_gap(8'hf4, 8'h55);       // invalid
        send_gap(8'hfe, 8'haa);
        send_gap(8'hff, 8'h00);
        send_gap(OpPushImm, 8'h5a);
        send_gap(8'hef, 8'h00);       // load sp from [0]
        send_gap(8'he1, 8'h77);       // store imm at [b]
        send_gap(OpNop, 8'h00);

        // Random part; long receiver hold-off early, sender drain midway
        n = 0;
        while (n < NumRandom) begin
            if (n == 100) hold_sink = 1'b1;
            if (n == 600) begin
                instr_if.valid <= 1'b0;
                while (sb.pending.size() != 0) @(posedge i_clk);
            end
            if ($urandom_range(9) == 0) op = 8'hf4 + 8'($urandom_range(3));
            else op = 8'($urandom_range(255));
            send_gap(op, rand_byte());
            n++;
        end
        instr_if.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DrainWait) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

// ===== files.f =====
design/ebrc_pkg.sv
design/ebrc_if.sv
design/ebrc_ram.sv
design/ebrc_div.sv
design/eight_bit_register_cpu_execute.sv
verif/tb.sv
